// ----- sv/block_to_colored_glyph_top_macros.svh -----
// assertion macros for the block-to-glyph converter
// expects i_clk and i_rst_n in the scope of use
`ifndef BLOCK_TO_COLORED_GLYPH_TOP_MACROS_SVH
`define BLOCK_TO_COLORED_GLYPH_TOP_MACROS_SVH
`ifndef SYNTH
`define B2CG_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define B2CG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define B2CG_ASSERT_NOW(lbl, pre, post)
`define B2CG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- sv/b2cg_pkg.sv -----
// shared types, command codes and widths of the block-to-glyph converter
// no dependencies
`default_nettype none
package b2cg_pkg;
    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int TGT_W = 11;
    localparam int DIST_W = 22;
    localparam int BEST_W = 24;
    localparam logic [BEST_W-1:0] DIST_START = 24'hffffff;
    localparam logic [23:0] CHANNEL_KEEP = 24'hfcfcfc;

    localparam logic [1:0] CMD_LOAD_PAL = 2'd0;
    localparam logic [1:0] CMD_LOAD_GLYPH = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    typedef logic signed [TGT_W-1:0] t_chan_tgt;
    typedef t_chan_tgt [2:0] t_target;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN1  = 6'b000010,
        ST_PRIM   = 6'b000100,
        ST_SCAN2  = 6'b001000,
        ST_GLYPH  = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    function automatic logic [7:0] chan(input logic [23:0] color, input logic [1:0] k);
        logic [7:0] r;
        r = 8'(color >> (8 * k));
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- sv/block_to_colored_glyph_top.sv -----
// convert: the result comes from two palette scans (one entry read per cycle plus the read
// register), the primary read, the glyph map read and the output load; input stalls until the
// cell moves into the output register, so no new convert is taken while one is in flight
// loads: no result, taken back to back while idle
// reset (synchronous, active low) clears control state only; palette and glyph map hold
`default_nettype none
`include "block_to_colored_glyph_top_macros.svh"
module block_to_colored_glyph_top #(
    parameter int PALETTE_ENTRIES = b2cg_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_table_index,
    input  wire logic [23:0] i_table_data,
    input  wire logic [23:0] i_pixel_top_left,
    input  wire logic [23:0] i_pixel_top_right,
    input  wire logic [23:0] i_pixel_bottom_left,
    input  wire logic [23:0] i_pixel_bottom_right,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_glyph,
    output logic [3:0]       o_primary_color,
    output logic [3:0]       o_secondary_color
);
    import b2cg_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PALETTE_ENTRIES - 1);

    logic [23:0] palette [PALETTE_ENTRIES];
    logic [7:0]  glyph_map [65536];

    t_state r_state, n_state;
    logic [23:0] r_px [4];
    logic [23:0] r_avg, r_prim, r_pal_q;
    logic [7:0]  r_glyph_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_cmp_v;
    logic [IDX_W-1:0] r_cmp_idx, r_pick, n_pick, r_prim_idx;
    logic [BEST_W-1:0] r_best, n_best;
    logic r_out_valid;
    logic [7:0] r_glyph;
    logic [3:0] r_prim_out, r_sec_out;

    logic accept, issue, last_cmp, out_load;
    logic [IDX_W-1:0] pal_rd_addr;
    logic [25:0] sum;
    t_target target;
    logic [DIST_W-1:0] pal_dist;
    logic [15:0] code;
    logic [3:0] nib [4];

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign issue = (r_state == ST_SCAN1 || r_state == ST_SCAN2) && (r_cnt != CNT_END);
    assign last_cmp = r_cmp_v && (r_cmp_idx == IDX_LAST);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign pal_rd_addr = (r_state == ST_PRIM) ? r_pick : r_cnt[IDX_W-1:0];

    always_comb begin
        sum = 26'({2'b00, i_pixel_top_left & CHANNEL_KEEP})
            + 26'({2'b00, i_pixel_top_right & CHANNEL_KEEP})
            + 26'({2'b00, i_pixel_bottom_left & CHANNEL_KEEP})
            + 26'({2'b00, i_pixel_bottom_right & CHANNEL_KEEP});
    end

    always_comb begin
        logic signed [8:0] diff;
        for (int k = 0; k < 3; k++) begin
            diff = $signed({1'b0, chan(r_avg, 2'(k))}) - $signed({1'b0, chan(r_prim, 2'(k))});
            if (r_state == ST_SCAN2) begin
                target[k] = {diff[8], diff, 1'b0};
            end else begin
                target[k] = $signed({3'b000, chan(r_avg, 2'(k))});
            end
        end
    end

    b2cg_dist u_dist (
        .i_color  (r_pal_q),
        .i_target (target),
        .o_dist   (pal_dist)
    );

    always_comb begin
        logic [7:0] a;
        logic [6:0] m;
        for (int p = 0; p < 4; p++) begin
            m = '0;
            for (int k = 0; k < 3; k++) begin
                if (chan(r_px[p], 2'(k)) >= chan(r_prim, 2'(k))) begin
                    a = chan(r_px[p], 2'(k)) - chan(r_prim, 2'(k));
                end else begin
                    a = chan(r_prim, 2'(k)) - chan(r_px[p], 2'(k));
                end
                if (a[6:0] > m) begin
                    m = a[6:0];
                end
            end
            nib[p] = m[6:3];
        end
        code = {nib[0], nib[1], nib[2], nib[3]};
    end

    always_comb begin
        n_state = r_state;
        n_cnt = issue ? r_cnt + 1'b1 : r_cnt;
        n_pick = r_pick;
        n_best = r_best;
        if (r_cmp_v && !(r_state == ST_SCAN2 && r_cmp_idx == r_prim_idx)) begin
            if ({2'b00, pal_dist} < r_best) begin
                n_best = {2'b00, pal_dist};
                n_pick = r_cmp_idx;
            end
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd == CMD_CONVERT) begin
                    n_state = ST_SCAN1;
                end
            end
            ST_SCAN1: begin
                if (last_cmp) begin
                    n_state = ST_PRIM;
                end
            end
            ST_PRIM: begin
                n_state = ST_SCAN2;
            end
            ST_SCAN2: begin
                if (last_cmp) begin
                    n_state = ST_GLYPH;
                end
            end
            ST_GLYPH: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // loads only happen in idle, so scans never see a write to the entry they read
    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_LOAD_PAL && i_table_index < 16'(PALETTE_ENTRIES)) begin
            palette[i_table_index[IDX_W-1:0]] <= i_table_data;
        end
        r_pal_q <= palette[pal_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_LOAD_GLYPH) begin
            glyph_map[i_table_index] <= i_table_data[7:0];
        end
        r_glyph_q <= glyph_map[code];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmp_v <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= issue;
            r_cnt <= (r_state == ST_PRIM || r_state == ST_IDLE) ? '0 : n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[IDX_W-1:0];
        if (accept) begin
            r_px[0] <= i_pixel_top_left;
            r_px[1] <= i_pixel_top_right;
            r_px[2] <= i_pixel_bottom_left;
            r_px[3] <= i_pixel_bottom_right;
            r_avg <= sum[25:2];
        end
        if (r_state == ST_IDLE || r_state == ST_PRIM) begin
            r_best <= DIST_START;
            r_pick <= '0;
        end else begin
            r_best <= n_best;
            r_pick <= n_pick;
        end
        if (r_state == ST_PRIM) begin
            r_prim_idx <= r_pick;
        end
        if (r_state == ST_SCAN2 && r_cnt == '0) begin
            r_prim <= r_pal_q;
        end
        if (out_load) begin
            r_glyph <= r_glyph_q;
            r_prim_out <= 4'(r_prim_idx);
            r_sec_out <= 4'(r_pick);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph = r_glyph;
    assign o_primary_color = r_prim_out;
    assign o_secondary_color = r_sec_out;

    `B2CG_ASSERT_NOW(a_cmp_in_scan, r_cmp_v, r_state == ST_SCAN1 || r_state == ST_SCAN2)
    `B2CG_ASSERT_NOW(a_sec_not_prim, r_state == ST_OUT, r_pick != r_prim_idx)
    `B2CG_ASSERT_NEXT(a_out_loads, r_state == ST_OUT && !r_out_valid, r_out_valid)
    `B2CG_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= CNT_END)
endmodule
`default_nettype wire

// ----- sv/b2cg_dist.sv -----
// squared distance between a palette color and a signed three-channel target
// depends on b2cg_pkg
`default_nettype none
module b2cg_dist (
    input  wire logic [23:0]                 i_color,
    input  wire b2cg_pkg::t_target           i_target,
    output logic [b2cg_pkg::DIST_W-1:0]      o_dist
);
    import b2cg_pkg::*;

    logic signed [11:0] e [3];
    logic signed [23:0] sq [3];

    always_comb begin
        o_dist = '0;
        for (int k = 0; k < 3; k++) begin
            e[k] = $signed({4'b0000, chan(i_color, 2'(k))})
                 - $signed({i_target[k][TGT_W-1], i_target[k]});
            sq[k] = e[k] * e[k];
            o_dist = o_dist + DIST_W'($unsigned(sq[k]));
        end
    end
endmodule
`default_nettype wire
